// ----- hdl/path_name_bucket_hash_defines.svh -----
`ifndef PATH_NAME_BUCKET_HASH_DEFINES_SVH
`define PATH_NAME_BUCKET_HASH_DEFINES_SVH

// Checks sample on clk_i and are off while rst_ni is low.
`define PNBH_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pnbh check failed");

`define PNBH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pnbh check failed");

`endif

// ----- hdl/pnbh_pkg.sv -----
`timescale 1ns / 1ps

package pnbh_pkg;

  localparam int unsigned HashW  = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 30;

  localparam logic [HashW-1:0] HashSeedXor = 32'd123456789;
  localparam int unsigned      RotRight    = 5;
  localparam int unsigned      RotLeft     = 27;
  localparam logic [ByteW-1:0] CharLowA    = 8'h61;
  localparam logic [ByteW-1:0] CharLowZ    = 8'h7a;
  localparam logic [ByteW-1:0] CaseOffset  = 8'h20;

  // one quotient bit per cycle over the 32-bit hash, the last step waiting for the result register
  localparam logic [4:0] DivLastStep = 5'd31;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic {
    BkIdle,
    BkDiv
  } bk_state_e;

  function automatic logic [ByteW-1:0] fold_upper(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] r;
    r = b;
    if (b >= CharLowA && b <= CharLowZ) begin
      r = b - CaseOffset;
    end
    return r;
  endfunction

  function automatic logic [HashW-1:0] mix_byte(input logic [HashW-1:0] h,
                                                input logic [ByteW-1:0] b);
    logic [HashW-1:0] rot;
    rot = (h >> RotRight) | (h << RotLeft);
    return rot ^ {{(HashW-ByteW){1'b0}}, fold_upper(b)};
  endfunction

endpackage

// ----- hdl/pnbh_front.sv -----
`timescale 1ns / 1ps

module pnbh_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [pnbh_pkg::HashW-1:0]  parent_offset_i,
  input  logic [pnbh_pkg::ByteW-1:0]  name_byte_i,
  input  logic                        first_byte_i,
  input  logic                        last_byte_i,
  input  logic                        no_byte_i,
  output logic                        q_push_o,
  output logic [pnbh_pkg::HashW-1:0]  q_data_o
);

  logic [pnbh_pkg::HashW-1:0] hash_q, hash_d;
  logic [pnbh_pkg::HashW-1:0] h_seed, h_mix;

  always_comb begin
    h_seed = first_byte_i ? (parent_offset_i ^ pnbh_pkg::HashSeedXor) : hash_q;
    h_mix  = no_byte_i ? h_seed : pnbh_pkg::mix_byte(h_seed, name_byte_i);
    hash_d = accept_i ? h_mix : hash_q;
  end

  assign q_push_o = accept_i && last_byte_i;
  assign q_data_o = h_mix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
    end else begin
      hash_q <= hash_d;
    end
  end

endmodule

// ----- hdl/pnbh_queue.sv -----
`timescale 1ns / 1ps

module pnbh_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [pnbh_pkg::HashW-1:0]  data_i,
  input  logic                        pop_i,
  output logic [pnbh_pkg::HashW-1:0]  data_o,
  output pnbh_pkg::q_stat_t           stat_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  logic [pnbh_pkg::HashW-1:0] mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntFull);
  assign stat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- hdl/pnbh_back.sv -----
`timescale 1ns / 1ps

module pnbh_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pnbh_pkg::CountW-1:0]  cfg_data_i,
  input  pnbh_pkg::q_stat_t            q_stat_i,
  input  logic [pnbh_pkg::HashW-1:0]   q_data_i,
  output logic                         q_pop_o,
  input  logic                         pop_i,
  output logic                         empty_o,
  output logic [pnbh_pkg::CountW-1:0]  bucket_index_o
);

  pnbh_pkg::bk_state_e state_q, state_d;

  logic [pnbh_pkg::CountW-1:0] count_q;
  logic [pnbh_pkg::CountW-1:0] divisor;
  logic [pnbh_pkg::HashW-1:0]  dvd_q, dvd_d;
  logic [pnbh_pkg::CountW-1:0] rem_q, rem_d;
  logic [4:0]                  step_q, step_d;
  logic [pnbh_pkg::CountW-1:0] out_q, out_d;
  logic                        out_vld_q, out_vld_d;
  logic [pnbh_pkg::CountW:0]   trial;
  logic [pnbh_pkg::CountW:0]   diff;
  logic [pnbh_pkg::CountW-1:0] rem_next;
  logic                        out_free;

  // a zero count acts as one bucket
  assign divisor = (count_q == '0) ? pnbh_pkg::CountW'(1) : count_q;

  assign trial    = {rem_q, dvd_q[pnbh_pkg::HashW-1]};
  assign diff     = trial - {1'b0, divisor};
  assign rem_next = (trial >= {1'b0, divisor}) ? diff[pnbh_pkg::CountW-1:0]
                                               : trial[pnbh_pkg::CountW-1:0];
  assign out_free = !out_vld_q || pop_i;

  always_comb begin
    state_d   = state_q;
    dvd_d     = dvd_q;
    rem_d     = rem_q;
    step_d    = step_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !pop_i;
    q_pop_o   = 1'b0;
    case (state_q)
      pnbh_pkg::BkIdle: begin
        if (!q_stat_i.empty) begin
          q_pop_o = 1'b1;
          dvd_d   = q_data_i;
          rem_d   = '0;
          step_d  = '0;
          state_d = pnbh_pkg::BkDiv;
        end
      end
      pnbh_pkg::BkDiv: begin
        // last step waits until the result register can take the beat
        if (step_q != pnbh_pkg::DivLastStep || out_free) begin
          rem_d  = rem_next;
          dvd_d  = dvd_q << 1;
          step_d = step_q + 1'b1;
          if (step_q == pnbh_pkg::DivLastStep) begin
            out_d     = rem_next;
            out_vld_d = 1'b1;
            state_d   = pnbh_pkg::BkIdle;
          end
        end
      end
      default: begin
        state_d = pnbh_pkg::BkIdle;
      end
    endcase
  end

  assign empty_o        = !out_vld_q;
  assign bucket_index_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pnbh_pkg::BkIdle;
      out_vld_q <= 1'b0;
      count_q   <= pnbh_pkg::CountW'(1);
      step_q    <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      step_q    <= step_d;
      if (cfg_we_i) begin
        count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    out_q <= out_d;
  end

endmodule

// ----- hdl/path_name_bucket_hash.sv -----
`timescale 1ns / 1ps

// Path name bucket hash. Push one name byte per beat; first_byte_i seeds the
// hash from parent_offset_i, no_byte_i marks a beat that carries no byte, and
// last_byte_i closes the name and queues a result. Bytes are taken at one per
// cycle while full_o is low. Each closed name then goes through a restoring
// divider that loads it and runs 32 steps at one quotient bit per cycle, the
// last step waiting while the result register is full; up to QDepth closed
// hashes wait in the queue ahead of it while bytes keep streaming. Write
// bucket_count through cfg_valid_i/cfg_data_i only while no name is in flight.
module path_name_bucket_hash #(
  parameter int unsigned QDepth = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pnbh_pkg::CountW-1:0]  cfg_data_i,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic [pnbh_pkg::HashW-1:0]   parent_offset_i,
  input  logic [pnbh_pkg::ByteW-1:0]   name_byte_i,
  input  logic                         first_byte_i,
  input  logic                         last_byte_i,
  input  logic                         no_byte_i,
  output logic                         empty_o,
  input  logic                         pop_i,
  output logic [pnbh_pkg::CountW-1:0]  bucket_index_o
);

  pnbh_pkg::q_stat_t          q_stat;
  logic                       q_push, q_pop;
  logic [pnbh_pkg::HashW-1:0] q_wdata, q_rdata;
  logic                       accept;

  assign cfg_ready_o = 1'b1;
  assign full_o      = q_stat.full;
  assign accept      = push_i && !q_stat.full;

  pnbh_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .parent_offset_i (parent_offset_i),
    .name_byte_i     (name_byte_i),
    .first_byte_i    (first_byte_i),
    .last_byte_i     (last_byte_i),
    .no_byte_i       (no_byte_i),
    .q_push_o        (q_push),
    .q_data_o        (q_wdata)
  );

  pnbh_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .stat_o (q_stat)
  );

  pnbh_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .q_stat_i       (q_stat),
    .q_data_i       (q_rdata),
    .q_pop_o        (q_pop),
    .pop_i          (pop_i),
    .empty_o        (empty_o),
    .bucket_index_o (bucket_index_o)
  );

endmodule

// ----- hdl/pnbh_checker.sv -----
`timescale 1ns / 1ps

`include "path_name_bucket_hash_defines.svh"

module pnbh_checker #(
  parameter int unsigned QDepth = 2
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_o,
  input logic [pnbh_pkg::CountW-1:0]  cfg_data_i,
  input logic                         push_i,
  input logic                         full_o,
  input logic                         last_byte_i,
  input logic                         empty_o,
  input logic                         pop_i,
  input logic [pnbh_pkg::CountW-1:0]  bucket_index_o
);

  // closed names can sit in the queue, the divider and the result register
  localparam int unsigned PendW = $clog2(QDepth + 3);

  logic [pnbh_pkg::CountW-1:0] count_q;
  logic [pnbh_pkg::CountW-1:0] eff_count;
  logic [PendW-1:0]            pend_q;
  logic                        in_last, out_beat;

  assign in_last   = push_i && !full_o && last_byte_i;
  assign out_beat  = pop_i && !empty_o;
  assign eff_count = (count_q == '0) ? pnbh_pkg::CountW'(1) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= pnbh_pkg::CountW'(1);
      pend_q  <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
      if (in_last && !out_beat) begin
        pend_q <= pend_q + 1'b1;
      end else if (out_beat && !in_last) begin
        pend_q <= pend_q - 1'b1;
      end
    end
  end

  `PNBH_ASSERT_NEXT(a_result_holds, !empty_o && !pop_i, !empty_o && $stable(bucket_index_o))
  `PNBH_ASSERT_IMPL(a_index_in_range, !empty_o, bucket_index_o < eff_count)
  `PNBH_ASSERT_IMPL(a_result_has_name, !empty_o, pend_q != '0)

endmodule

bind path_name_bucket_hash pnbh_checker #(.QDepth(QDepth)) u_pnbh_checker (.*);

// ----- bench/tb_path_name_bucket_hash.sv -----
`timescale 1ns / 1ps

module tb_path_name_bucket_hash;

  localparam int unsigned StallLimit = 4000;  // cycles with no beat on any port
  localparam int unsigned SettleCyc  = 40;    // divider load + 32 steps, plus margin
  localparam int unsigned BatchItems = 150;
  localparam logic [pnbh_pkg::CountW-1:0] CountMax = {pnbh_pkg::CountW{1'b1}};

  typedef struct packed {
    logic [pnbh_pkg::HashW-1:0] parent;
    logic [pnbh_pkg::ByteW-1:0] chr;
    logic                       first;
    logic                       last;
    logic                       none;
  } name_beat_t;

  typedef struct {
    logic [pnbh_pkg::CountW-1:0] index;
    longint unsigned             stamp;
  } bucket_due_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [pnbh_pkg::CountW-1:0] cfg_data_i = '0;
  logic                        push_i = 1'b0;
  logic                        full_o;
  logic [pnbh_pkg::HashW-1:0]  parent_offset_i = '0;
  logic [pnbh_pkg::ByteW-1:0]  name_byte_i = '0;
  logic                        first_byte_i = 1'b0;
  logic                        last_byte_i = 1'b0;
  logic                        no_byte_i = 1'b0;
  logic                        empty_o;
  logic                        pop_i = 1'b0;
  logic [pnbh_pkg::CountW-1:0] bucket_index_o;

  name_beat_t  beats_to_send[$];
  bucket_due_t bucket_due[$];

  // predictor state
  logic [pnbh_pkg::HashW-1:0]  hash_acc = '0;
  logic [pnbh_pkg::CountW-1:0] bucket_cnt = pnbh_pkg::CountW'(1);

  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned fail_cnt = 0;
  int unsigned stall_cnt = 0;

  path_name_bucket_hash i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .push_i         (push_i),
    .full_o         (full_o),
    .parent_offset_i(parent_offset_i),
    .name_byte_i    (name_byte_i),
    .first_byte_i   (first_byte_i),
    .last_byte_i    (last_byte_i),
    .no_byte_i      (no_byte_i),
    .empty_o        (empty_o),
    .pop_i          (pop_i),
    .bucket_index_o (bucket_index_o)
  );

  always #6 clk_i = ~clk_i;

  task automatic report_miss(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_cnt++;
  endtask

  // fold a-z to upper case, rotate right by five, xor the byte in; a closing beat queues its bucket index
  task automatic hash_beat(input name_beat_t b);
    logic [pnbh_pkg::HashW-1:0] h;
    logic [pnbh_pkg::ByteW-1:0] c;
    logic [pnbh_pkg::HashW-1:0] div;
    bucket_due_t                d;
    h = hash_acc;
    if (b.first) h = b.parent ^ pnbh_pkg::HashSeedXor;
    if (!b.none) begin
      c = b.chr;
      if (c >= pnbh_pkg::CharLowA && c <= pnbh_pkg::CharLowZ) c[5] = 1'b0;
      h = {h[pnbh_pkg::RotRight-1:0], h[pnbh_pkg::HashW-1:pnbh_pkg::RotRight]}
          ^ {{(pnbh_pkg::HashW-pnbh_pkg::ByteW){1'b0}}, c};
    end
    hash_acc = h;
    if (b.last) begin
      div = (bucket_cnt == '0) ? 32'd1
                               : {{(pnbh_pkg::HashW-pnbh_pkg::CountW){1'b0}}, bucket_cnt};
      d.index = pnbh_pkg::CountW'(h % div);
      d.stamp = $time;
      bucket_due.push_back(d);
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin : drv
    name_beat_t nb;
    if (!rst_ni) begin
      push_i <= 1'b0;
    end else begin
      if (push_i && !full_o) begin
        nb = '{parent_offset_i, name_byte_i, first_byte_i, last_byte_i, no_byte_i};
        hash_beat(nb);
      end
      if (!push_i || !full_o) begin
        if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle) begin
          nb = beats_to_send.pop_front();
          push_i          <= 1'b1;
          parent_offset_i <= nb.parent;
          name_byte_i     <= nb.chr;
          first_byte_i    <= nb.first;
          last_byte_i     <= nb.last;
          no_byte_i       <= nb.none;
        end else begin
          push_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin : mon
    bucket_due_t d;
    if (!rst_ni) begin
      pop_i <= 1'b0;
    end else begin
      if (pop_i && !empty_o) begin
        // an expectation stamped this step belongs to a beat taken at this very edge
        if (bucket_due.size() == 0 || bucket_due[0].stamp == $time) begin
          report_miss($sformatf("bucket_index %0d with no name closed", bucket_index_o));
        end else begin
          d = bucket_due.pop_front();
          if (bucket_index_o !== d.index)
            report_miss($sformatf("bucket_index got %0d want %0d", bucket_index_o, d.index));
        end
      end
      pop_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    if ((push_i && !full_o) || (pop_i && !empty_o) || (cfg_valid_i && cfg_ready_o)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic wait_drained(input bit settle);
    do @(negedge clk_i);
    while (beats_to_send.size() != 0 || push_i || bucket_due.size() != 0);
    if (settle) repeat (SettleCyc) @(negedge clk_i);
  endtask

  task automatic write_count(input logic [pnbh_pkg::CountW-1:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    cfg_valid_i <= 1'b0;
    bucket_cnt = v;
  endtask

  task automatic add_beat(input logic [pnbh_pkg::HashW-1:0] parent,
                          input logic [pnbh_pkg::ByteW-1:0] chr,
                          input bit first, input bit last, input bit none);
    name_beat_t nb;
    nb = '{parent, chr, first, last, none};
    beats_to_send.push_back(nb);
  endtask

  function automatic logic [pnbh_pkg::ByteW-1:0] pick_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return pnbh_pkg::ByteW'($urandom_range(8'h7a, 8'h61));
    if (r < 75) return pnbh_pkg::ByteW'($urandom_range(8'h5a, 8'h30));
    return pnbh_pkg::ByteW'($urandom_range(255));
  endfunction

  task automatic add_random(input int unsigned n_items);
    int unsigned cnt;
    int unsigned len;
    int unsigned r;
    logic [pnbh_pkg::HashW-1:0] parent;
    cnt = 0;
    while (cnt < n_items) begin
      r = $urandom_range(99);
      parent = $urandom;
      if (r < 8) begin
        // noise: any mix of flags
        add_beat(parent, pnbh_pkg::ByteW'($urandom), 1'($urandom_range(1)),
                 1'($urandom_range(1)), 1'($urandom_range(1)));
        cnt++;
      end else if (r < 14) begin
        add_beat(parent, pnbh_pkg::ByteW'($urandom), 1'b1, 1'b1, 1'b1);
        cnt++;
      end else begin
        len = ($urandom_range(19) == 0) ? $urandom_range(40, 20) : $urandom_range(10, 1);
        for (int unsigned i = 0; i < len; i++) begin
          add_beat((i == 0) ? parent : pnbh_pkg::HashW'($urandom), pick_char(), i == 0,
                   i == len - 1, (i != 0) && ($urandom_range(19) == 0));
        end
        cnt += len;
      end
    end
  endtask

  task automatic add_directed();
    // continue from the reset hash without a start
    add_beat('0, "a", 1'b0, 1'b0, 1'b0);
    add_beat('0, 8'hff, 1'b0, 1'b1, 1'b0);
    // empty names at both parent extremes
    add_beat('0, 8'h55, 1'b1, 1'b1, 1'b1);
    add_beat('1, 8'haa, 1'b1, 1'b1, 1'b1);
    // case folding edges: letters and their neighbors
    add_beat(32'hdeadbeef, "a", 1'b1, 1'b0, 1'b0);
    add_beat(32'h0, "z", 1'b0, 1'b0, 1'b0);
    add_beat(32'h0, 8'h60, 1'b0, 1'b0, 1'b0);
    add_beat(32'h0, 8'h7b, 1'b0, 1'b0, 1'b0);
    add_beat(32'h0, "A", 1'b0, 1'b0, 1'b0);
    add_beat(32'h0, "Z", 1'b0, 1'b0, 1'b0);
    add_beat(32'hffffffff, 8'hff, 1'b0, 1'b0, 1'b1);
    add_beat(32'h0, 8'h00, 1'b0, 1'b1, 1'b0);
    add_beat('1, "m", 1'b1, 1'b1, 1'b0);
    // a closing beat that carries no byte
    add_beat(32'h12345678, "q", 1'b1, 1'b0, 1'b0);
    add_beat(32'h0, "q", 1'b0, 1'b1, 1'b1);
    // continue after a finished name
    add_beat(32'h0, "x", 1'b0, 1'b1, 1'b0);
    // start with no byte, then bytes
    add_beat(32'h80000001, 8'h00, 1'b1, 1'b0, 1'b1);
    add_beat(32'h0, 8'h80, 1'b0, 1'b0, 1'b0);
    add_beat(32'h0, 8'h7f, 1'b0, 1'b1, 1'b0);
  endtask

  initial begin
    logic [pnbh_pkg::CountW-1:0] counts[12];
    counts[0]  = CountMax;
    counts[1]  = '0;
    counts[2]  = pnbh_pkg::CountW'(1);
    counts[3]  = pnbh_pkg::CountW'($urandom_range(1000, 1));
    counts[4]  = pnbh_pkg::CountW'($urandom);
    counts[5]  = CountMax;
    counts[6]  = pnbh_pkg::CountW'($urandom_range(64, 2));
    counts[7]  = '0;
    counts[8]  = pnbh_pkg::CountW'($urandom);
    counts[9]  = pnbh_pkg::CountW'(1) << (pnbh_pkg::CountW - 1);
    counts[10] = pnbh_pkg::CountW'($urandom_range(1000, 1));
    counts[11] = pnbh_pkg::CountW'(3);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < 3; p++) begin
      send_idle = (p == 0) ? 6 : (p == 1) ? 69 : 0;
      recv_idle = (p == 0) ? 69 : (p == 1) ? 6 : 0;
      for (int k = 0; k < 4; k++) begin
        write_count(counts[p*4 + k]);
        if (p == 0 && k == 0) add_directed();
        if (k == 1) begin
          // sender holds off until every bucket index is out
          add_random(BatchItems / 2);
          wait_drained(1'b0);
          add_random(BatchItems / 2);
        end else begin
          add_random(BatchItems);
        end
        wait_drained(1'b1);
      end
    end

    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
